// File: rtl/trial_division_prime_test_top_defines.svh
// ----------------------------------------------------------------------------
// Trial division prime test: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// Same-cycle implication.
`define TDPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test: package
// Widths, controller states and the command/status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

    // Operand width and the widths that follow from it.
    localparam int VALUE_W = 32;
    localparam int DIV_W   = VALUE_W / 2;
    localparam int SQ_W    = VALUE_W + 1;
    localparam int CNT_W   = $clog2(VALUE_W);

    // First trial divisor and its square.
    localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(3);
    localparam logic [SQ_W-1:0]  FIRST_SQ  = SQ_W'(9);
    localparam logic [CNT_W-1:0] TOP_BIT   = CNT_W'(VALUE_W - 1);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_BOUND,
        ST_DIVIDE,
        ST_TEST,
        ST_REPORT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init_trial;
        logic div_step;
        logic next_div;
        logic set_result;
        logic result_val;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;
        logic trivial_prime;
        logic bound_ok;
        logic div_last;
        logic rem_zero;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// Trial division prime test: controller
// Sequences screening, the divisor bound check, the serial remainder and
// the report strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire tdpt_pkg::dp_sts_t sts,
    output tdpt_pkg::dp_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);
    import tdpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCREEN;
                end
            end
            ST_SCREEN:
            begin
                state_next = sts.trivial ? ST_REPORT : ST_BOUND;
            end
            ST_BOUND:
            begin
                state_next = sts.bound_ok ? ST_DIVIDE : ST_REPORT;
            end
            ST_DIVIDE:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                state_next = sts.rem_zero ? ST_REPORT : ST_BOUND;
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCREEN:
            begin
                if (sts.trivial)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = sts.trivial_prime;
                end
                else
                begin
                    cmd.init_trial = 1'b1;
                end
            end
            ST_BOUND:
            begin
                // No divisor up to the square root divides: prime.
                if (!sts.bound_ok)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_TEST:
            begin
                if (sts.rem_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = 1'b0;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                end
            end
            ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tdpt_dpath.sv
// ----------------------------------------------------------------------------
// Trial division prime test: datapath
// Holds the operand, the trial divisor and its square, and a restoring
// remainder unit that retires one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_dpath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic signed [tdpt_pkg::VALUE_W-1:0] value,
    input  wire tdpt_pkg::dp_cmd_t                   cmd,
    output tdpt_pkg::dp_sts_t                        sts,
    output logic                                     is_prime
);
    import tdpt_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [DIV_W-1:0]   div_next;
    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    sq_next;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   rem_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               result_reg;
    logic               result_next;
    logic [DIV_W:0]     shifted;

    // One restoring remainder step: bring in the next dividend bit.
    always_comb
    begin
        shifted  = {rem_reg, value_reg[cnt_reg]};
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        div_next = div_reg;
        sq_next  = sq_reg;
        if (cmd.init_trial)
        begin
            div_next = FIRST_DIV;
            sq_next  = FIRST_SQ;
            rem_next = '0;
            cnt_next = TOP_BIT;
        end
        else if (cmd.next_div)
        begin
            // (d + 2)^2 = d^2 + 4d + 4
            div_next = div_reg + DIV_W'(2);
            sq_next  = sq_reg + {{(SQ_W-DIV_W-2){1'b0}}, div_reg, 2'b00} + SQ_W'(4);
            rem_next = '0;
            cnt_next = TOP_BIT;
        end
        else if (cmd.div_step)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = DIV_W'(shifted - {1'b0, div_reg});
            end
            else
            begin
                rem_next = shifted[DIV_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Result flag.
    always_comb
    begin
        result_next = cmd.set_result ? cmd.result_val : result_reg;
    end

    // Operand and trial registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            div_reg   <= FIRST_DIV;
            sq_reg    <= FIRST_SQ;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                value_reg <= VALUE_W'(value);
            end
            div_reg    <= div_next;
            sq_reg     <= sq_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= 1'b0;
        end
        else
        begin
            result_reg <= result_next;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.trivial       = value_reg[VALUE_W-1] || !value_reg[0]
                            || (value_reg < VALUE_W'(3));
        sts.trivial_prime = (value_reg == VALUE_W'(2));
        sts.bound_ok      = (sq_reg <= {1'b0, value_reg});
        sts.div_last      = (cnt_reg == '0);
        sts.rem_zero      = (rem_reg == '0);
    end

    assign is_prime = result_reg;

endmodule

`default_nettype wire

// File: rtl/trial_division_prime_test_top.sv
// ----------------------------------------------------------------------------
// Trial division prime test: top level
// Tests one signed integer for primality by trial division with odd
// divisors from three up to the square root.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Data
//  -------   -----------------------   --------------------------
//  input     start, busy (taken when   value (32 bits, signed)
//            start high, busy low)
//  result    done (one-cycle strobe)   is_prime (1 bit)
//
// Negative, zero, one and even values go from the transfer in through screen
// and report, where done shows; a new value is then taken back in idle.
// For odd values each trial divisor takes one bound check, a pass of the
// bit-serial remainder unit over every dividend bit and one test. A large
// prime near 2^31 needs about 23170 trials. Reset clears the controller and
// the datapath registers at once. The receiver cannot stall; busy stays
// high until done has shown.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trial_division_prime_test_top_defines.svh"

module trial_division_prime_test_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [tdpt_pkg::VALUE_W-1:0] value,
    output logic                                     done,
    output logic                                     is_prime
);
    import tdpt_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer.
    tdpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Operand, divisor and remainder unit.
    tdpt_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .cmd      (cmd),
        .sts      (sts),
        .is_prime (is_prime)
    );

    // A transfer in makes the block busy on the next cycle.
    `TDPT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "not busy after transfer")
    // The result strobe lasts one cycle only.
    `TDPT_ASSERT_NEXT(a_done_single, done, !done && !busy, "done strobe not single")
    // A remainder step never coincides with a new divisor or a result.
    `TDPT_ASSERT_NOW(a_cmd_excl, cmd.div_step, !cmd.next_div && !cmd.set_result,
        "conflicting datapath commands")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trial division prime test: testbench
// Sends signed integers to the prime tester through the start/busy command
// port and checks every is_prime strobe against a trial-division predictor.
// Directed values cover the screened cases, the trial loop and the field
// extremes; random phases follow with varied sender idling.
// ----------------------------------------------------------------------------

module tb_top;

    import tdpt_pkg::*;

    // The limit leaves room for a prime near the top of the range, which runs the whole trial loop.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_CYCLES = 40;

    // One expected verdict, kept with the value that produced it.
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      is_prime;
    } verdict_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      busy;
    logic                      done;
    logic                      is_prime;

    verdict_t    pending_verdicts[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    trial_division_prime_test_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .done     (done),
        .is_prime (is_prime)
    );

    // Free-running 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Primality by trial division over odd divisors up to the square root.
    function automatic logic predict_prime(input logic signed [VALUE_W-1:0] candidate);
        longint unsigned n;
        longint unsigned divisor;
        if (candidate < 0)
            return 1'b0;
        n = candidate;
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (divisor = 3; divisor * divisor <= n; divisor += 2)
        begin
            if (n % divisor == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Random candidate. Odd values that may run the full trial loop are kept
    // small so that the run stays short; large odd values always carry a
    // small factor and finish within a few trials.
    function automatic logic signed [VALUE_W-1:0] draw_candidate();
        int unsigned sel;
        int unsigned factor;
        int unsigned span;
        int unsigned root;
        sel = $urandom_range(99);
        if (sel < 30)
            return 2 * $urandom_range(1, 2047) + 1;
        else if (sel < 40)
        begin
            root = 2 * $urandom_range(1, 127) + 1;
            return root * root;
        end
        else if (sel < 45)
            return 2 * $urandom_range(0, 131071) + 1;
        else if (sel < 60)
        begin
            factor = 2 * $urandom_range(1, 15) + 1;
            span = 32'h7FFF_FFFF / factor;
            return factor * (2 * $urandom_range(0, (span - 1) / 2) + 1);
        end
        else if (sel < 75)
            return $urandom() | 32'h8000_0000;
        else if (sel < 90)
            return $urandom() & 32'h7FFF_FFFE;
        else
            return $urandom_range(0, 2);
    endfunction

    // Count a failure; only the first few are printed.
    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Offer one value, wait for its transfer, and record the verdict due.
    // Start stays high unless an idle gap is drawn.
    task automatic send_value(input logic signed [VALUE_W-1:0] candidate,
                              input int unsigned idle_pct);
        verdict_t entry;
        start <= 1'b1;
        value <= candidate;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        entry.value = candidate;
        entry.is_prime = predict_prime(candidate);
        pending_verdicts.push_back(entry);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every outstanding verdict has arrived.
    task automatic drain_verdicts();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Values settled by the screen: negatives, zero, one, two and evens.
    task automatic test_screened_values();
        logic signed [VALUE_W-1:0] cases[$] = {
            32'sh8000_0000, -32'sd1, -32'sd2, -32'sd7, 32'sd0, 32'sd1,
            32'sd2, 32'sd4, 32'sd6, 32'sh7FFF_FFFE, 32'sh4000_0000
        };
        foreach (cases[i])
            send_value(cases[i], 0);
        drain_verdicts();
    endtask

    // Odd values through the trial loop: small primes below the first bound,
    // odd squares, larger primes, composites and the largest positive value.
    task automatic test_trial_divisions();
        logic signed [VALUE_W-1:0] cases[$] = {
            32'sd3, 32'sd5, 32'sd7, 32'sd9, 32'sd15, 32'sd25, 32'sd49,
            32'sd121, 32'sd961, 32'sd97, 32'sd65537, 32'sd2147483643,
            32'sd2147483645, 32'sh7FFF_FFFF
        };
        foreach (cases[i])
            send_value(cases[i], 0);
        drain_verdicts();
    endtask

    // One random phase at a given sender idle rate.
    task automatic test_random_values(input int unsigned idle_pct,
                                      input int unsigned count);
        repeat (count)
            send_value(draw_candidate(), idle_pct);
        drain_verdicts();
    endtask

    // Compare each result strobe with the oldest verdict due.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
                note_failure($sformatf("unexpected result is_prime=%0b", is_prime));
            else
            begin
                if (is_prime !== pending_verdicts[0].is_prime)
                    note_failure($sformatf("value=%0d expected is_prime=%0b actual=%0b",
                                           pending_verdicts[0].value,
                                           pending_verdicts[0].is_prime, is_prime));
                void'(pending_verdicts.pop_front());
            end
        end
    end

    // Cycle counter and watchdog.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_screened_values();
        test_trial_divisions();
        test_random_values(0, 25);
        test_random_values(46, 25);
        test_random_values(38, 25);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tdpt_pkg.sv
rtl/tdpt_ctrl.sv
rtl/tdpt_dpath.sv
rtl/trial_division_prime_test_top.sv
tb/tb_top.sv
